[src/cfp_pkg.sv]
package cfp_pkg;

  localparam logic [1:0] KIND_DC      = 2'd0;
  localparam logic [1:0] KIND_AC      = 2'd1;
  localparam logic [1:0] KIND_IGNORED = 2'd2;
  localparam logic [1:0] KIND_BADSUM  = 2'd3;

  localparam logic [7:0] LEN_MAX   = 8'd253;
  localparam logic [7:0] CMD_INFO  = 8'h20;
  localparam logic [7:0] SUB_DC    = 8'hFD;
  localparam logic [7:0] SUB_AC    = 8'h01;
  localparam logic [7:0] PAY_FIRST = 8'd7;
  localparam logic [7:0] PAY_LAST  = 8'd14;

  localparam int QUEUE_DEPTH = 2;

  // p / 1000 == (p >> 3) / 125, the latter by reciprocal with one correction
  localparam int          DIV_SHIFT   = 3;
  localparam logic [6:0]  DIV_REST    = 7'd125;
  localparam int          RECIP_SHIFT = 36;
  localparam logic [29:0] RECIP       = 30'd549755813;

  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0][7:0] payload;
  } frame_rec_t;

endpackage

[src/cfp_in_if.sv]
interface cfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

[src/cfp_out_if.sv]
interface cfp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         frame_kind;
  logic [15:0]        battery_voltage;
  logic signed [23:0] battery_current;
  logic [21:0]        ac_power;

  modport source (output valid, output frame_kind, output battery_voltage,
                  output battery_current, output ac_power, input ready);
  modport sink (input valid, input frame_kind, input battery_voltage,
                input battery_current, input ac_power, output ready);
endinterface

[src/cfp_front.sv]
module cfp_front (
  input  logic                clk,
  input  logic                rst,
  cfp_in_if.sink              rx,
  output logic                push_valid,
  output cfp_pkg::frame_rec_t push_data,
  input  logic                push_ready
);
  import cfp_pkg::*;

  logic [7:0]      byte_count, frame_length, running_sum, command_byte, subtype_byte;
  logic [7:0][7:0] payload_bytes;

  logic [7:0]      byte_count_next, frame_length_next, running_sum_next;
  logic [7:0]      command_byte_next, subtype_byte_next;
  logic [7:0][7:0] payload_bytes_next;

  logic       accept, oversize, frame_end;
  logic [7:0] b;
  logic [8:0] pos_inc;
  logic [1:0] kind;

  assign rx.ready = push_ready;
  assign accept   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;
  assign oversize = (byte_count == 8'd0) && (b > LEN_MAX);

  always_comb begin
    frame_length_next  = frame_length;
    running_sum_next   = running_sum;
    command_byte_next  = command_byte;
    subtype_byte_next  = subtype_byte;
    payload_bytes_next = payload_bytes;
    if (byte_count == 8'd0) begin
      frame_length_next = b;
      running_sum_next  = b;
    end else begin
      running_sum_next = running_sum + b;
      if (byte_count == 8'd1) begin
        command_byte_next = b;
      end else if (byte_count == 8'd2) begin
        subtype_byte_next = b;
      end else if (byte_count >= PAY_FIRST && byte_count <= PAY_LAST) begin
        payload_bytes_next[3'(byte_count - PAY_FIRST)] = b;
      end
    end
    pos_inc         = {1'b0, byte_count} + 9'd1;
    frame_end       = pos_inc >= ({1'b0, frame_length_next} + 9'd2);
    byte_count_next = frame_end ? 8'd0 : pos_inc[7:0];

    if (running_sum_next != 8'd0) begin
      kind = KIND_BADSUM;
    end else if (command_byte_next == CMD_INFO && subtype_byte_next == SUB_DC) begin
      kind = KIND_DC;
    end else if (command_byte_next == CMD_INFO && subtype_byte_next == SUB_AC) begin
      kind = KIND_AC;
    end else begin
      kind = KIND_IGNORED;
    end
  end

  assign push_valid        = accept && (oversize || frame_end);
  assign push_data.kind    = oversize ? KIND_IGNORED : kind;
  assign push_data.payload = payload_bytes_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      frame_length  <= '0;
      running_sum   <= '0;
      command_byte  <= '0;
      subtype_byte  <= '0;
      payload_bytes <= '0;
    end else if (accept && !oversize) begin
      byte_count    <= byte_count_next;
      frame_length  <= frame_length_next;
      running_sum   <= running_sum_next;
      command_byte  <= command_byte_next;
      subtype_byte  <= subtype_byte_next;
      payload_bytes <= payload_bytes_next;
    end
  end

  a_count_in_frame: assert property (@(posedge clk) disable iff (rst)
    {1'b0, byte_count} <= ({1'b0, frame_length} + 9'd1))
    else $error("byte count ran past frame end");

  a_oversize_drops: assert property (@(posedge clk) disable iff (rst)
    (accept && oversize) |=> (byte_count == 8'd0))
    else $error("oversized length byte started a frame");

endmodule

[src/cfp_queue.sv]
module cfp_queue #(
  parameter int DEPTH = cfp_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  cfp_pkg::frame_rec_t push_data,
  output logic                push_ready,
  output logic                pop_valid,
  output cfp_pkg::frame_rec_t pop_data,
  input  logic                pop_ready
);
  import cfp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_rec_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a push");

endmodule

[src/cfp_back.sv]
module cfp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  input  cfp_pkg::frame_rec_t pop_data,
  output logic                pop_ready,
  cfp_out_if.source           result
);
  import cfp_pkg::*;

  logic        en;
  logic [15:0] v_raw, i_raw, i_mag;

  logic        a_valid, b_valid, c_valid;
  logic [1:0]  a_kind, b_kind, c_kind;
  logic [15:0] a_volt, b_volt, c_volt;
  logic [23:0] a_cur, b_cur, c_cur;
  logic [31:0] a_prod;
  logic [28:0] b_x;
  logic [58:0] b_t;
  logic [21:0] c_power;

  logic [22:0] q_est;
  logic [29:0] rem;
  logic [22:0] q_fix;

  assign en        = !c_valid || result.ready;
  assign pop_ready = en;

  assign v_raw = {pop_data.payload[5], pop_data.payload[4]};
  assign i_raw = {pop_data.payload[7], pop_data.payload[6]};
  assign i_mag = (pop_data.kind != KIND_AC) ? 16'd0 :
                 i_raw[15] ? (16'd0 - i_raw) : i_raw;

  assign q_est = b_t[RECIP_SHIFT +: 23];
  assign rem   = {1'b0, b_x} - (30'(q_est) * 30'(DIV_REST));
  assign q_fix = (rem >= 30'(DIV_REST)) ? q_est + 23'd1 : q_est;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (en) begin
      a_valid <= pop_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_kind <= pop_data.kind;
      a_volt <= (pop_data.kind == KIND_DC) ?
                {pop_data.payload[1], pop_data.payload[0]} : 16'd0;
      a_cur  <= (pop_data.kind == KIND_DC) ?
                {pop_data.payload[4], pop_data.payload[3], pop_data.payload[2]} : 24'd0;
      a_prod <= 32'(v_raw) * 32'(i_mag);

      b_kind <= a_kind;
      b_volt <= a_volt;
      b_cur  <= a_cur;
      b_x    <= a_prod[31:DIV_SHIFT];
      b_t    <= 59'(a_prod[31:DIV_SHIFT]) * 59'(RECIP);

      c_kind  <= b_kind;
      c_volt  <= b_volt;
      c_cur   <= b_cur;
      c_power <= (b_kind == KIND_AC) ? q_fix[21:0] : 22'd0;
    end
  end

  assign result.valid           = c_valid;
  assign result.frame_kind      = c_kind;
  assign result.battery_voltage = c_volt;
  assign result.battery_current = signed'(c_cur);
  assign result.ac_power        = c_power;

  a_power_only_ac: assert property (@(posedge clk) disable iff (rst)
    (c_valid && c_kind != KIND_AC) |-> (c_power == 22'd0))
    else $error("power field set on a non-ac item");

  a_dc_fields: assert property (@(posedge clk) disable iff (rst)
    (c_valid && c_kind != KIND_DC) |-> (c_volt == 16'd0 && c_cur == 24'd0))
    else $error("dc fields set on a non-dc item");

endmodule

[src/checksummed_frame_parser.sv]
// channel  dir  fields                                                    accepted
// rx       in   rx_byte[7:0]                                              valid && ready
// result   out  frame_kind[1:0], battery_voltage[15:0],                   valid && ready
//               battery_current[23:0] signed, ac_power[21:0]
// one byte per cycle while rx.ready is high; a result passes through the queue and the back end
// three-stage back end: 16x16 product, reciprocal product, divide correction
// two-entry queue between front and back; rx.ready drops only when it is full
// synchronous reset clears byte count, sum, stored bytes, queue and pipeline
module checksummed_frame_parser #(
  parameter int QUEUE_DEPTH = cfp_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  cfp_in_if.sink    rx,
  cfp_out_if.source result
);
  import cfp_pkg::*;

  logic       push_valid, push_ready, pop_valid, pop_ready;
  frame_rec_t push_data, pop_data;

  cfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  cfp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  cfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .result    (result)
  );

endmodule
